>>> rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// types, constants and the midpoint function for the gasket subdivider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sts_pkg;

  localparam int MaxLevels = 8;
  localparam int CoordW    = 16;
  localparam int PathW     = 16;
  localparam int LevelW    = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int CntW      = (LevelW > $clog2(MaxLevels + 1)) ? LevelW
                                                              : $clog2(MaxLevels + 1);

  localparam logic [CfgIdxW-1:0] RegAX     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAY     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBX     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBY     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCX     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCY     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLevels = 3'd6;

  localparam logic [1:0] DigitLower = 2'd0;
  localparam logic [1:0] DigitLeft  = 2'd1;
  localparam logic [1:0] DigitRight = 2'd2;

  localparam logic signed [CoordW-1:0] ResetAX = -16'sd16384;
  localparam logic signed [CoordW-1:0] ResetAY = -16'sd16384;
  localparam logic signed [CoordW-1:0] ResetBX = 16'sd0;
  localparam logic signed [CoordW-1:0] ResetBY = 16'sd16384;
  localparam logic signed [CoordW-1:0] ResetCX = 16'sd16384;
  localparam logic signed [CoordW-1:0] ResetCY = -16'sd16384;
  localparam logic [LevelW-1:0]        ResetLevels = 4'd1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
  } tri_t;

  typedef struct packed {
    logic [PathW-1:0] path;
    logic             bad;
    tri_t             corners;
  } stage_t;

  // floor of the half sum, exact over the widened sum
  function automatic logic signed [CoordW-1:0] half_sum(
    input logic signed [CoordW-1:0] p,
    input logic signed [CoordW-1:0] q
  );
    logic signed [CoordW:0] s;
    s = {p[CoordW-1], p} + {q[CoordW-1], q};
    return s[CoordW:1];
  endfunction

  function automatic point_t midpoint(input point_t p, input point_t q);
    point_t m;
    m.x = half_sum(p.x, q.x);
    m.y = half_sum(p.y, q.y);
    return m;
  endfunction

endpackage

>>> rtl/sierpinski_triangle_subdivider.sv
// ----------------------------------------------------------------------------
// sierpinski_triangle_subdivider
// every leaf passes through all stage registers from input transfer to output valid
// throughput: one leaf per cycle while out_stall is low, whatever the level count; one level per stage
// stall holds each full stage with no empty stage after it; the rest still move (bubble removal)
// reset (rst, synchronous): pipeline empty, corners and level count to defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sierpinski_triangle_subdivider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sts_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [sts_pkg::CfgDataW-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sts_pkg::PathW-1:0]         leaf_path,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [sts_pkg::CoordW-1:0] out_x0,
  output logic signed [sts_pkg::CoordW-1:0] out_y0,
  output logic signed [sts_pkg::CoordW-1:0] out_x1,
  output logic signed [sts_pkg::CoordW-1:0] out_y1,
  output logic signed [sts_pkg::CoordW-1:0] out_x2,
  output logic signed [sts_pkg::CoordW-1:0] out_y2,
  output logic                              bad_path
);

  localparam int Last = sts_pkg::MaxLevels - 1;

  sts_pkg::tri_t               outer;
  logic [sts_pkg::LevelW-1:0]  levels;
  logic [sts_pkg::CntW-1:0]    levels_ext;
  logic [sts_pkg::CntW-1:0]    levels_eff;

  sts_pkg::stage_t             st      [sts_pkg::MaxLevels];
  sts_pkg::stage_t             st_next [sts_pkg::MaxLevels];
  logic [sts_pkg::MaxLevels-1:0] vld;
  logic [sts_pkg::MaxLevels-1:0] adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      outer.a.x <= sts_pkg::ResetAX;
      outer.a.y <= sts_pkg::ResetAY;
      outer.b.x <= sts_pkg::ResetBX;
      outer.b.y <= sts_pkg::ResetBY;
      outer.c.x <= sts_pkg::ResetCX;
      outer.c.y <= sts_pkg::ResetCY;
      levels    <= sts_pkg::ResetLevels;
    end else if (cfg_we) begin
      case (cfg_index)
        sts_pkg::RegAX:     outer.a.x <= cfg_data[sts_pkg::CoordW-1:0];
        sts_pkg::RegAY:     outer.a.y <= cfg_data[sts_pkg::CoordW-1:0];
        sts_pkg::RegBX:     outer.b.x <= cfg_data[sts_pkg::CoordW-1:0];
        sts_pkg::RegBY:     outer.b.y <= cfg_data[sts_pkg::CoordW-1:0];
        sts_pkg::RegCX:     outer.c.x <= cfg_data[sts_pkg::CoordW-1:0];
        sts_pkg::RegCY:     outer.c.y <= cfg_data[sts_pkg::CoordW-1:0];
        sts_pkg::RegLevels: levels    <= cfg_data[sts_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  // clamp level count to 1..MaxLevels
  always_comb begin
    levels_ext = sts_pkg::CntW'(levels);
    if (levels_ext == '0) begin
      levels_eff = sts_pkg::CntW'(1);
    end else if (levels_ext > sts_pkg::CntW'(sts_pkg::MaxLevels)) begin
      levels_eff = sts_pkg::CntW'(sts_pkg::MaxLevels);
    end else begin
      levels_eff = levels_ext;
    end
  end

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[Last] = !vld[Last] || !out_stall;
    for (int i = Last - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i + 1];
    end
  end

  assign in_stall = !adv[0];

  for (genvar k = 0; k < sts_pkg::MaxLevels; k++) begin : g_level
    sts_pkg::stage_t src;
    logic            src_vld;
    logic [1:0]      digit;
    logic            active;
    sts_pkg::point_t ab;
    sts_pkg::point_t bc;
    sts_pkg::point_t ca;

    if (k == 0) begin : g_first
      always_comb begin
        src.path    = leaf_path;
        src.bad     = 1'b0;
        src.corners = outer;
        src_vld     = in_valid;
      end
    end else begin : g_rest
      always_comb begin
        src     = st[k - 1];
        src_vld = vld[k - 1];
      end
    end

    if (2 * k + 1 < sts_pkg::PathW) begin : g_digit
      assign digit = src.path[2 * k +: 2];
    end else begin : g_zero
      assign digit = sts_pkg::DigitLower;
    end

    assign active = sts_pkg::CntW'(k) < levels_eff;

    always_comb begin
      ab = sts_pkg::midpoint(src.corners.a, src.corners.b);
      bc = sts_pkg::midpoint(src.corners.b, src.corners.c);
      ca = sts_pkg::midpoint(src.corners.c, src.corners.a);
      st_next[k] = src;
      if (active) begin
        case (digit)
          sts_pkg::DigitLower: begin
            st_next[k].corners.b = ab;
            st_next[k].corners.c = ca;
          end
          sts_pkg::DigitLeft: begin
            st_next[k].corners.a = ab;
            st_next[k].corners.c = bc;
          end
          sts_pkg::DigitRight: begin
            st_next[k].corners.a = ca;
            st_next[k].corners.b = bc;
          end
          default: begin
            st_next[k].bad = 1'b1;
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign out_valid = vld[Last];
  assign bad_path  = st[Last].bad;
  assign out_x0    = st[Last].bad ? '0 : st[Last].corners.a.x;
  assign out_y0    = st[Last].bad ? '0 : st[Last].corners.a.y;
  assign out_x1    = st[Last].bad ? '0 : st[Last].corners.b.x;
  assign out_y1    = st[Last].bad ? '0 : st[Last].corners.b.y;
  assign out_x2    = st[Last].bad ? '0 : st[Last].corners.c.x;
  assign out_y2    = st[Last].bad ? '0 : st[Last].corners.c.y;

endmodule
